// ===== rtl/ecf_pkg.sv =====
// Shared constants, command/status types and state codes of the crossfade selector.
package ecf_pkg;

    localparam int FADE_W = 20;
    localparam int CCNT_W = 7;
    localparam int CHAN_W = 6;
    localparam int GAIN_W = 16;

    localparam int MAX_CHANNELS = 64;
    localparam int DEF_SAMPLE_BITS = 24;
    localparam int DEF_SINE_TABLE_DEPTH = 256;

    localparam logic [FADE_W-1:0] FADE_LENGTH_RESET = FADE_W'(2205);
    localparam logic [CCNT_W-1:0] CHANNEL_COUNT_RESET = CCNT_W'(8);

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic signed [63:0] Q30_ONE = 64'sd1073741824;
    localparam logic [63:0] GAIN_ONE = 64'd32768;

    // configuration register indexes
    localparam logic CFG_FADE_LENGTH = 1'b0;
    localparam logic CFG_CHANNEL_COUNT = 1'b1;

    // input item commands
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_SELECT = 1'b1;

    typedef struct packed {
        logic accept;    // input transfer this cycle
        logic prep;      // load divider operands
        logic div_step;  // one quotient bit
        logic rd_a;      // read active gain
        logic mul_a;     // active product, read previous gain
        logic mul_b;     // previous product
        logic sum;       // add products
        logic rnd;       // round and saturate
        logic out_load;  // load output register
    } t_dp_cmd;

    typedef struct packed {
        logic frame_item;   // offered item is a frame-end sample
        logic fade_active;  // fade counter not yet at -1
        logic div_last;     // last divider step
        logic out_free;     // output register can take a result
    } t_dp_stat;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_PREP = 9'b000000010,
        S_DIV  = 9'b000000100,
        S_RDA  = 9'b000001000,
        S_MULA = 9'b000010000,
        S_MULB = 9'b000100000,
        S_SUM  = 9'b001000000,
        S_RND  = 9'b010000000,
        S_OUT  = 9'b100000000
    } t_state;

endpackage

// ===== rtl/ecf_ctrl.sv =====
// Sequencer of the crossfade selector: steps the datapath through one frame-end result.
module ecf_ctrl
    import ecf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_stat.frame_item) begin
                        n_state = i_stat.fade_active ? S_PREP : S_OUT;
                    end
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_RDA;
                end
            end
            S_RDA: begin
                o_cmd.rd_a = 1'b1;
                n_state    = S_MULA;
            end
            S_MULA: begin
                o_cmd.mul_a = 1'b1;
                n_state     = S_MULB;
            end
            S_MULB: begin
                o_cmd.mul_b = 1'b1;
                n_state     = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_RND;
            end
            S_RND: begin
                o_cmd.rnd = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_div_to_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) && i_stat.div_last |=> (r_state == S_RDA))
        else $error("divider end did not advance to gain read");

endmodule

// ===== rtl/ecf_dp.sv =====
// Datapath of the crossfade selector: state, phase divider, gain table, shared multiplier.
module ecf_dp
    import ecf_pkg::*;
#(
    parameter int SAMPLE_BITS      = DEF_SAMPLE_BITS,
    parameter int SINE_TABLE_DEPTH = DEF_SINE_TABLE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_dp_cmd                       i_cmd,
    output t_dp_stat                      o_stat,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [FADE_W-1:0]             i_cfg_wdata,
    input  logic                          i_command,
    input  logic [CHAN_W-1:0]             i_channel,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_frame_end,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic signed [SAMPLE_BITS-1:0] o_mixed_sample,
    output logic                          o_fading,
    output logic [CHAN_W-1:0]             o_active_channel_out
);

    localparam int KW = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int CW = $clog2(KW + 1);
    localparam int NW = FADE_W + KW;
    localparam int PW = SAMPLE_BITS + GAIN_W + 1;
    localparam int AW = PW + 1;
    localparam int SW = AW - 14;
    localparam longint SAT_HI_L = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
    localparam logic signed [SW-1:0] SAT_HI = SW'(SAT_HI_L);
    localparam logic signed [SW-1:0] SAT_LO = SW'(-SAT_HI_L - 64'sd1);

    // Quarter-sine gain, Q1.15, from an odd Taylor series in Q30.
    function automatic logic [GAIN_W-1:0] sine_gain(input int unsigned k);
        logic [63:0]        t;
        logic [63:0]        t2;
        logic [63:0]        term;
        logic signed [63:0] acc;
        logic [63:0]        q;
        t    = (64'(k) * HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
        t2   = (t * t) >> 30;
        term = t;
        acc  = signed'(t);
        term = ((term * t2) >> 30) / 64'd6;
        acc  = acc - signed'(term);
        term = ((term * t2) >> 30) / 64'd20;
        acc  = acc + signed'(term);
        term = ((term * t2) >> 30) / 64'd42;
        acc  = acc - signed'(term);
        term = ((term * t2) >> 30) / 64'd72;
        acc  = acc + signed'(term);
        term = ((term * t2) >> 30) / 64'd110;
        acc  = acc - signed'(term);
        if (acc < 0) begin
            acc = 0;
        end
        if (acc > Q30_ONE) begin
            acc = Q30_ONE;
        end
        q = (unsigned'(acc) + 64'd16384) >> 15;
        if (q > GAIN_ONE) begin
            q = GAIN_ONE;
        end
        return q[GAIN_W-1:0];
    endfunction

    logic [GAIN_W-1:0] w_gain_tab [SINE_TABLE_DEPTH + 1];
    for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_tab
        assign w_gain_tab[g] = sine_gain(g);
    end

    // architectural state
    logic [FADE_W-1:0]             r_len;
    logic [CCNT_W-1:0]             r_ccnt;
    logic [CHAN_W-1:0]             r_act;
    logic [CHAN_W-1:0]             r_prev;
    logic [FADE_W:0]               r_rem;
    logic signed [SAMPLE_BITS-1:0] r_alatch;
    logic signed [SAMPLE_BITS-1:0] r_platch;
    logic                          r_fade_job;
    logic                          r_out_valid;
    logic [CW-1:0]                 r_cnt;

    // working registers
    logic [FADE_W-1:0]             r_part;
    logic [KW-1:0]                 r_nlow;
    logic [KW-1:0]                 r_k;
    logic [GAIN_W-1:0]             r_gain;
    logic signed [PW-1:0]          r_prod_a;
    logic signed [PW-1:0]          r_prod_b;
    logic signed [AW-1:0]          r_acc;
    logic signed [SAMPLE_BITS-1:0] r_res;

    // output register
    logic signed [SAMPLE_BITS-1:0] r_mixed;
    logic                          r_fading;
    logic [CHAN_W-1:0]             r_act_out;

    logic [FADE_W-1:0]             w_rem_u;
    logic [FADE_W-1:0]             w_rem_c;
    logic [FADE_W-1:0]             w_d;
    logic [NW-1:0]                 w_n;
    logic [FADE_W:0]               w_shift;
    logic                          w_ge;
    logic [FADE_W:0]               w_sub;
    logic [KW-1:0]                 w_addr;
    logic signed [SAMPLE_BITS-1:0] w_mul_in;
    logic signed [PW-1:0]          w_prod;
    logic [AW-1:0]                 w_mag;
    logic [AW-1:0]                 w_mag_r;
    logic [AW-16:0]                w_rnd;
    logic signed [SW-1:0]          w_sres;
    logic signed [SAMPLE_BITS-1:0] w_sat;
    logic                          w_sel_ok;
    logic [CCNT_W-1:0]             w_ccnt_v;

    // phase numerator (length - remaining) * depth
    assign w_rem_u = r_rem[FADE_W-1:0];
    assign w_rem_c = (w_rem_u > r_len) ? r_len : w_rem_u;
    assign w_d     = r_len - w_rem_c;
    assign w_n     = NW'(w_d) * NW'(SINE_TABLE_DEPTH);

    // one restoring division step
    assign w_shift = {r_part, r_nlow[KW-1]};
    assign w_ge    = (w_shift >= {1'b0, r_len});
    assign w_sub   = w_shift - {1'b0, r_len};

    assign w_addr   = i_cmd.mul_a ? (KW'(SINE_TABLE_DEPTH) - r_k) : r_k;
    assign w_mul_in = i_cmd.mul_b ? r_platch : r_alatch;
    assign w_prod   = w_mul_in * $signed({1'b0, r_gain});

    // round half away from zero, then saturate
    assign w_mag   = r_acc[AW-1] ? AW'(-r_acc) : AW'(r_acc);
    assign w_mag_r = w_mag + AW'(16384);
    assign w_rnd   = w_mag_r[AW-1:15];
    assign w_sres  = r_acc[AW-1] ? -$signed({1'b0, w_rnd}) : $signed({1'b0, w_rnd});
    always_comb begin
        if (w_sres > SAT_HI) begin
            w_sat = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
        end else if (w_sres < SAT_LO) begin
            w_sat = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
        end else begin
            w_sat = w_sres[SAMPLE_BITS-1:0];
        end
    end

    assign w_sel_ok = ({1'b0, i_channel} < r_ccnt) && (i_channel != r_act);

    always_comb begin
        w_ccnt_v = i_cfg_wdata[CCNT_W-1:0];
        if (w_ccnt_v < CCNT_W'(2)) begin
            w_ccnt_v = CCNT_W'(2);
        end else if (w_ccnt_v > CCNT_W'(MAX_CHANNELS)) begin
            w_ccnt_v = CCNT_W'(MAX_CHANNELS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= FADE_LENGTH_RESET;
            r_ccnt      <= CHANNEL_COUNT_RESET;
            r_act       <= '0;
            r_prev      <= '0;
            r_rem       <= '0;
            r_alatch    <= '0;
            r_platch    <= '0;
            r_fade_job  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (i_cmd.accept) begin
                if (i_command == CMD_SELECT) begin
                    if (w_sel_ok) begin
                        r_prev <= r_act;
                        r_act  <= i_channel;
                        r_rem  <= {1'b0, r_len};
                    end
                end else begin
                    if (i_channel == r_act) begin
                        r_alatch <= i_sample;
                    end
                    if (i_channel == r_prev) begin
                        r_platch <= i_sample;
                    end
                    if (i_frame_end) begin
                        r_fade_job <= !r_rem[FADE_W];
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_FADE_LENGTH) begin
                    r_len <= (i_cfg_wdata == '0) ? FADE_W'(1) : i_cfg_wdata;
                    r_rem <= '0;
                end else begin
                    r_ccnt <= w_ccnt_v;
                end
            end
            if (i_cmd.prep) begin
                r_cnt <= CW'(KW);
            end else if (i_cmd.div_step) begin
                r_cnt <= r_cnt - CW'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
                if (r_fade_job) begin
                    r_rem <= r_rem - (FADE_W + 1)'(1);
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_part <= w_n[NW-1:KW];
            r_nlow <= w_n[KW-1:0];
            r_k    <= '0;
        end else if (i_cmd.div_step) begin
            r_part <= w_ge ? w_sub[FADE_W-1:0] : w_shift[FADE_W-1:0];
            r_nlow <= r_nlow << 1;
            r_k    <= {r_k[KW-2:0], w_ge};
        end
        if (i_cmd.rd_a || i_cmd.mul_a) begin
            r_gain <= w_gain_tab[w_addr];
        end
        if (i_cmd.mul_a) begin
            r_prod_a <= w_prod;
        end
        if (i_cmd.mul_b) begin
            r_prod_b <= w_prod;
        end
        if (i_cmd.sum) begin
            r_acc <= AW'(r_prod_a) + AW'(r_prod_b);
        end
        if (i_cmd.rnd) begin
            r_res <= w_sat;
        end
        if (i_cmd.out_load) begin
            r_mixed   <= r_fade_job ? r_res : r_alatch;
            r_fading  <= r_fade_job;
            r_act_out <= r_act;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_mixed_sample       = r_mixed;
    assign o_fading             = r_fading;
    assign o_active_channel_out = r_act_out;
    assign o_stat.frame_item    = (i_command == CMD_SAMPLE) && i_frame_end;
    assign o_stat.fade_active   = !r_rem[FADE_W];
    assign o_stat.div_last      = (r_cnt == CW'(1));
    assign o_stat.out_free      = !r_out_valid || i_out_ready;

    a_rem_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem[FADE_W] |-> (&r_rem))
        else $error("fade counter went below minus one");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_a |-> (r_k <= KW'(SINE_TABLE_DEPTH)))
        else $error("phase index beyond table depth");

endmodule

// ===== rtl/equal_power_crossfade_selector.sv =====
// Top level of the equal-power crossfade channel selector.
//
// Takes channel-serial audio, one sample per input transfer with a frame-end
// flag, and emits one output transfer per frame-end sample: the active
// channel's latched sample, or during a crossfade the equal-power mix
// active*sin(p) + previous*cos(p), rounded and saturated to SAMPLE_BITS.
// A select item (command 1) naming an in-range channel other than the active
// one starts a fade of fade_length + 1 frames; select items never produce output.
// A select or a plain sample is taken in idle and leaves the block idle. A
// frame-end sample with no fade running goes from idle to the output state,
// which loads its result into the output register. During a fade it steps
// through prep, divide, gain read, both multiplies, sum, round and output: a
// restoring divider of KW = clog2(SINE_TABLE_DEPTH + 1) quotient bits gives
// the phase index, one quotient bit per cycle, then two gain lookups share one
// registered table port and the two products share one multiplier. A finished
// result waits in the output register while the next item is taken; the block
// only stalls at the end of a computation when that register is still full.
// Configuration writes are to be made only while the block is idle; the block
// itself does not enforce this. Writing fade_length also clears the fade counter.
module equal_power_crossfade_selector
    import ecf_pkg::*;
#(
    parameter int SAMPLE_BITS      = DEF_SAMPLE_BITS,
    parameter int SINE_TABLE_DEPTH = DEF_SINE_TABLE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [FADE_W-1:0]             i_cfg_wdata,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_command,
    input  logic [CHAN_W-1:0]             i_channel,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_frame_end,
    // output channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [SAMPLE_BITS-1:0] o_mixed_sample,
    output logic                          o_fading,
    output logic [CHAN_W-1:0]             o_active_channel_out
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Sequencer: accepts items in idle and walks the fade computation.
    ecf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Datapath: channel state, latches, divider, gain table, multiplier, output register.
    ecf_dp #(
        .SAMPLE_BITS      (SAMPLE_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (w_cmd),
        .o_stat               (w_stat),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_wdata          (i_cfg_wdata),
        .i_command            (i_command),
        .i_channel            (i_channel),
        .i_sample             (i_sample),
        .i_frame_end          (i_frame_end),
        .i_out_ready          (i_out_ready),
        .o_out_valid          (o_out_valid),
        .o_mixed_sample       (o_mixed_sample),
        .o_fading             (o_fading),
        .o_active_channel_out (o_active_channel_out)
    );

    // Never overwrite a result that has not been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_stat.out_free)
        else $error("output register loaded while still holding a result");

endmodule
